@@ sv/dmc_pkg.sv @@
// ----------------------------------------------------------------------------
// dmc_pkg
// Types and constants shared by the door motor controller files.
// ----------------------------------------------------------------------------
package dmc_pkg;

  // Door machine states, coded as reported on door_state
  typedef enum logic [2:0] {
    ST_INIT    = 3'd0,
    ST_STOP    = 3'd1,
    ST_OPENING = 3'd2,
    ST_OPENED  = 3'd3,
    ST_CLOSING = 3'd4,
    ST_ERROR   = 3'd5
  } dmc_state_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_HOLD_OPEN     = 2'd0,
    CFG_BLINK_HALF    = 2'd1,
    CFG_MOTOR_TIMEOUT = 2'd2
  } dmc_cfg_idx_e;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ElapsedW = 8;

  // Register reset values
  localparam logic [CfgDataW-1:0] HoldOpenRst     = 16'd5000;
  localparam logic [CfgDataW-1:0] BlinkHalfRst    = 16'd200;
  localparam logic [CfgDataW-1:0] MotorTimeoutRst = 16'd10000;

  // One scan of the door inputs
  typedef struct packed {
    logic                open_request;
    logic                other_door_closed;
    logic                open_limit;
    logic                closed_limit;
    logic                light_barrier;
    logic [ElapsedW-1:0] elapsed_ms;
  } dmc_in_t;

  // Outputs after one scan
  typedef struct packed {
    logic       motor_open;
    logic       motor_close;
    logic       lamp;
    logic [2:0] door_state;
  } dmc_out_t;

endpackage

@@ sv/dmc_timer.sv @@
// ----------------------------------------------------------------------------
// dmc_timer
// On-delay timer with saturating elapsed count, advanced once per scan.
// ----------------------------------------------------------------------------
module dmc_timer #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic                           run_i,
  input  logic [dmc_pkg::CfgDataW-1:0]   preset_i,
  input  logic [dmc_pkg::ElapsedW-1:0]   elapsed_ms_i,
  output logic                           done_o
);
  import dmc_pkg::*;

  logic [TIMER_BITS-1:0] elapsed_q, elapsed_d;
  logic                  was_in_q;
  logic                  done_q, done_d;
  logic [TIMER_BITS-1:0] preset;
  logic [TIMER_BITS:0]   sum;

  // Fit the preset to the timer width
  assign preset = TIMER_BITS'(preset_i);
  assign sum    = {1'b0, elapsed_q} + (TIMER_BITS + 1)'(elapsed_ms_i);

  // Restart on a rising input, otherwise count and saturate at the preset
  always_comb begin
    if (!run_i || !was_in_q) begin
      elapsed_d = '0;
    end else if (sum > {1'b0, preset}) begin
      elapsed_d = preset;
    end else begin
      elapsed_d = sum[TIMER_BITS-1:0];
    end
    done_d = run_i && (elapsed_d >= preset);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      was_in_q  <= 1'b0;
      done_q    <= 1'b0;
    end else if (step_i) begin
      elapsed_q <= elapsed_d;
      was_in_q  <= run_i;
      done_q    <= done_d;
    end
  end

  assign done_o = done_q;

endmodule

@@ sv/door_motor_controller.sv @@
// ----------------------------------------------------------------------------
// door_motor_controller
// Automatic door controller with partner-door interlock and three timers.
// ----------------------------------------------------------------------------
// Each input transaction is one scan of the door inputs and yields exactly one
// result transaction. A scan is captured in an input register; once the result
// register is free it runs one step of the door machine and the hold-open,
// lamp-blink and motor-run timers and lands in the result register. A new scan
// can be accepted every cycle while the result side does not stall. The result
// register is the only thing that can hold back the input; configuration writes
// are always taken (ready is tied high) and must be made while no scan is in flight.
module door_motor_controller #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  dmc_pkg::dmc_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dmc_pkg::dmc_out_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dmc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dmc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import dmc_pkg::*;

  // Configuration registers
  logic [CfgDataW-1:0] hold_cfg_q, blink_cfg_q, tout_cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cfg_q  <= HoldOpenRst;
      blink_cfg_q <= BlinkHalfRst;
      tout_cfg_q  <= MotorTimeoutRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HOLD_OPEN:     hold_cfg_q  <= cfg_data_i;
        CFG_BLINK_HALF:    blink_cfg_q <= cfg_data_i;
        CFG_MOTOR_TIMEOUT: tout_cfg_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register and result register handshake
  logic     s1_valid_q;
  dmc_in_t  s1_data_q;
  logic     out_valid_q;
  dmc_out_t out_data_q;
  logic     advance;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_data_q <= in_data_i;
    end
  end

  // Door machine state
  dmc_state_e mode_q, mode_d;
  logic       drv_open_q, drv_open_d;
  logic       drv_close_q, drv_close_d;
  logic       lamp_q, lamp_d;
  logic       hold_req_q, hold_req_d;
  logic       blink_req_q, blink_req_d;
  logic       hold_done, blink_done, run_done;
  logic       run_in;

  always_comb begin
    mode_d      = mode_q;
    drv_open_d  = drv_open_q;
    drv_close_d = drv_close_q;
    lamp_d      = lamp_q;
    hold_req_d  = hold_req_q;
    blink_req_d = blink_req_q;
    unique case (mode_q)
      ST_INIT: begin
        // Motors keep their drive here
        lamp_d = 1'b0;
        mode_d = s1_data_q.closed_limit ? ST_STOP : ST_CLOSING;
      end
      ST_STOP: begin
        drv_open_d  = 1'b0;
        drv_close_d = 1'b0;
        lamp_d      = 1'b0;
        if (s1_data_q.open_request && s1_data_q.other_door_closed) begin
          mode_d = ST_OPENING;
        end
      end
      ST_OPENING: begin
        drv_open_d  = 1'b1;
        drv_close_d = 1'b0;
        lamp_d      = 1'b0;
        if (s1_data_q.open_limit) begin
          mode_d = ST_OPENED;
        end
      end
      ST_OPENED: begin
        drv_open_d  = 1'b0;
        drv_close_d = 1'b0;
        lamp_d      = 1'b0;
        hold_req_d  = 1'b1;
        if (hold_done) begin
          hold_req_d = 1'b0;
          mode_d     = ST_CLOSING;
        end
      end
      ST_CLOSING: begin
        drv_open_d  = 1'b0;
        drv_close_d = 1'b1;
        blink_req_d = 1'b1;
        if (blink_done) begin
          blink_req_d = 1'b0;
          lamp_d      = !lamp_q;
        end
        // Request or barrier over closed limit
        if (s1_data_q.open_request || s1_data_q.light_barrier) begin
          mode_d = ST_OPENING;
        end else if (s1_data_q.closed_limit) begin
          mode_d = ST_STOP;
        end
      end
      ST_ERROR: begin
        drv_open_d  = 1'b0;
        drv_close_d = 1'b0;
        lamp_d      = 1'b1;
        if (s1_data_q.open_request && s1_data_q.other_door_closed) begin
          mode_d = ST_OPENING;
        end
      end
      default: ;
    endcase
    run_in = drv_open_d || drv_close_d;
    // Motor run timeout overrides every state transition
    if (run_done) begin
      mode_d = ST_ERROR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ST_INIT;
      drv_open_q  <= 1'b0;
      drv_close_q <= 1'b0;
      lamp_q      <= 1'b0;
      hold_req_q  <= 1'b0;
      blink_req_q <= 1'b0;
    end else if (advance) begin
      mode_q      <= mode_d;
      drv_open_q  <= drv_open_d;
      drv_close_q <= drv_close_d;
      lamp_q      <= lamp_d;
      hold_req_q  <= hold_req_d;
      blink_req_q <= blink_req_d;
    end
  end

  // Timers, advanced with the scan; the machine sees last scan's done flags
  dmc_timer #(.TIMER_BITS(TIMER_BITS)) u_hold_timer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .run_i        (hold_req_d),
    .preset_i     (hold_cfg_q),
    .elapsed_ms_i (s1_data_q.elapsed_ms),
    .done_o       (hold_done)
  );

  dmc_timer #(.TIMER_BITS(TIMER_BITS)) u_blink_timer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .run_i        (blink_req_d),
    .preset_i     (blink_cfg_q),
    .elapsed_ms_i (s1_data_q.elapsed_ms),
    .done_o       (blink_done)
  );

  dmc_timer #(.TIMER_BITS(TIMER_BITS)) u_run_timer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .run_i        (run_in),
    .preset_i     (tout_cfg_q),
    .elapsed_ms_i (s1_data_q.elapsed_ms),
    .done_o       (run_done)
  );

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q.motor_open  <= drv_open_d;
      out_data_q.motor_close <= drv_close_d;
      out_data_q.lamp        <= lamp_d;
      out_data_q.door_state  <= mode_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ test/door_motor_controller_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// door_motor_controller_checker
// Watches the scan, result and register channels of the door controller,
// predicts every result from its own copy of the door machine, the three
// on-delay timers and the timer presets, and compares each result field by
// field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module door_motor_controller_checker
  import dmc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                scan_valid_i,
  input  logic                scan_stall_i,
  input  dmc_in_t             scan_data_i,
  input  logic                result_valid_i,
  input  logic                result_stall_i,
  input  dmc_out_t            result_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         pending_o,
  output int unsigned         error_count_o
);

  localparam int unsigned TimerW     = 16;
  localparam int unsigned MaxPrinted = 50;

  // One on-delay timer: elapsed time, done flag and last scan's input
  typedef struct packed {
    logic [TimerW-1:0] elapsed;
    logic              done;
    logic              was_on;
  } delay_t;

  logic [CfgDataW-1:0] hold_ms;
  logic [CfgDataW-1:0] blink_ms;
  logic [CfgDataW-1:0] timeout_ms;

  dmc_state_e door_mode;
  logic       drive_open;
  logic       drive_close;
  logic       lamp_on;
  logic       hold_latch;
  logic       blink_latch;
  delay_t     hold_tmr;
  delay_t     blink_tmr;
  delay_t     run_tmr;

  dmc_out_t    predicted_q [$];
  int unsigned results_seen;

  // Print one line per mismatch (up to a cap) and count it
  task automatic report_mismatch(string what);
    if (error_count_o < MaxPrinted) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    error_count_o++;
  endtask

  // Advance one timer by the scan's elapsed time; a fresh start counts nothing
  function automatic delay_t advance_delay(delay_t t, logic running,
                                           logic [TimerW-1:0] preset,
                                           logic [ElapsedW-1:0] ms);
    logic [TimerW:0] sum;
    sum = t.elapsed + ms;
    if (!running || !t.was_on) begin
      t.elapsed = '0;
    end else if (sum > preset) begin
      t.elapsed = preset;
    end else begin
      t.elapsed = sum[TimerW-1:0];
    end
    t.done   = running && (t.elapsed >= preset);
    t.was_on = running;
    return t;
  endfunction

  // Run one scan of the door machine and timers, return the outputs after it
  function automatic dmc_out_t scan_door(dmc_in_t s);
    dmc_out_t r;
    logic     motor_on;
    case (door_mode)
      ST_INIT: begin
        // motors keep whatever they had
        lamp_on   = 1'b0;
        door_mode = s.closed_limit ? ST_STOP : ST_CLOSING;
      end
      ST_STOP: begin
        {drive_open, drive_close, lamp_on} = 3'b000;
        if (s.open_request && s.other_door_closed) door_mode = ST_OPENING;
      end
      ST_OPENING: begin
        {drive_open, drive_close, lamp_on} = 3'b100;
        if (s.open_limit) door_mode = ST_OPENED;
      end
      ST_OPENED: begin
        {drive_open, drive_close, lamp_on} = 3'b000;
        hold_latch = 1'b1;
        if (hold_tmr.done) begin
          hold_latch = 1'b0;
          door_mode  = ST_CLOSING;
        end
      end
      ST_CLOSING: begin
        {drive_open, drive_close} = 2'b01;
        blink_latch = 1'b1;
        if (blink_tmr.done) begin
          blink_latch = 1'b0;
          lamp_on     = !lamp_on;
        end
        // request or barrier beats closed limit
        if (s.closed_limit) door_mode = ST_STOP;
        if (s.light_barrier || s.open_request) door_mode = ST_OPENING;
      end
      ST_ERROR: begin
        {drive_open, drive_close, lamp_on} = 3'b001;
        if (s.open_request && s.other_door_closed) door_mode = ST_OPENING;
      end
      default: ;
    endcase

    // a motor timeout from the last scan overrides every state transition
    motor_on = drive_open || drive_close;
    if (run_tmr.done) door_mode = ST_ERROR;

    hold_tmr  = advance_delay(hold_tmr, hold_latch, hold_ms, s.elapsed_ms);
    blink_tmr = advance_delay(blink_tmr, blink_latch, blink_ms, s.elapsed_ms);
    run_tmr   = advance_delay(run_tmr, motor_on, timeout_ms, s.elapsed_ms);

    r.motor_open  = drive_open;
    r.motor_close = drive_close;
    r.lamp        = lamp_on;
    r.door_state  = door_mode;
    return r;
  endfunction

  task automatic reset_model();
    hold_ms     = HoldOpenRst;
    blink_ms    = BlinkHalfRst;
    timeout_ms  = MotorTimeoutRst;
    door_mode   = ST_INIT;
    drive_open  = 1'b0;
    drive_close = 1'b0;
    lamp_on     = 1'b0;
    hold_latch  = 1'b0;
    blink_latch = 1'b0;
    hold_tmr    = '0;
    blink_tmr   = '0;
    run_tmr     = '0;
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    case (dmc_cfg_idx_e'(idx))
      CFG_HOLD_OPEN:     hold_ms    = val;
      CFG_BLINK_HALF:    blink_ms   = val;
      CFG_MOTOR_TIMEOUT: timeout_ms = val;
      default: ;
    endcase
  endtask

  // Compare a result transaction against the oldest prediction
  task automatic check_result(dmc_out_t got);
    dmc_out_t want;
    if (predicted_q.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
    end else begin
      want = predicted_q.pop_front();
      if (got.motor_open !== want.motor_open)
        report_mismatch($sformatf("result %0d motor_open %b, expected %b",
                                  results_seen, got.motor_open, want.motor_open));
      if (got.motor_close !== want.motor_close)
        report_mismatch($sformatf("result %0d motor_close %b, expected %b",
                                  results_seen, got.motor_close, want.motor_close));
      if (got.lamp !== want.lamp)
        report_mismatch($sformatf("result %0d lamp %b, expected %b",
                                  results_seen, got.lamp, want.lamp));
      if (got.door_state !== want.door_state)
        report_mismatch($sformatf("result %0d door_state %0d, expected %0d",
                                  results_seen, got.door_state, want.door_state));
    end
    results_seen++;
  endtask

  // Track register writes, scans and results at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_model();
      predicted_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) write_register(cfg_index_i, cfg_data_i);
      if (result_valid_i && !result_stall_i) check_result(result_data_i);
      if (scan_valid_i && !scan_stall_i) predicted_q.push_back(scan_door(scan_data_i));
      pending_o <= predicted_q.size();
    end
  end

endmodule

@@ test/door_motor_controller_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// door_motor_controller_tb
// Drives scans and timer presets into the door controller and gives the
// verdict. A short directed run walks the door through its states with reset,
// zero and full-scale presets; random phases then send door cycles and noise
// bursts with idle gaps and result stalls, including one long stall.
// ----------------------------------------------------------------------------
module door_motor_controller_tb;
  import dmc_pkg::*;

  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned ScansPerPhase = 90;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                scan_valid   = 1'b0;
  dmc_in_t             scan_data    = '0;
  logic                scan_stall;
  logic                result_valid;
  logic                result_stall = 1'b0;
  dmc_out_t            result_data;
  logic                cfg_valid    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index    = '0;
  logic [CfgDataW-1:0] cfg_data     = '0;
  logic                cfg_ready;
  int unsigned         pending;
  int unsigned         error_count;

  int unsigned scans_sent     = 0;
  int unsigned cycle_count    = 0;
  int unsigned rx_count       = 0;
  int unsigned ms_lo          = 0;
  int unsigned ms_hi          = 255;
  logic        tx_quiet       = 1'b0;
  logic        hold_off_req   = 1'b0;
  logic        hold_off_taken = 1'b0;

  door_motor_controller u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (scan_valid),
    .in_stall_o  (scan_stall),
    .in_data_i   (scan_data),
    .out_valid_o (result_valid),
    .out_stall_i (result_stall),
    .out_data_o  (result_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  door_motor_controller_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .scan_valid_i   (scan_valid),
    .scan_stall_i   (scan_stall),
    .scan_data_i    (scan_data),
    .result_valid_i (result_valid),
    .result_stall_i (result_stall),
    .result_data_i  (result_data),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .pending_o      (pending),
    .error_count_o  (error_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic chance(int unsigned pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // Mostly no gap, sometimes a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [ElapsedW-1:0] tick();
    return ElapsedW'($urandom_range(ms_hi, ms_lo));
  endfunction

  function automatic dmc_in_t door_scan(logic req, logic partner_shut, logic at_open,
                                        logic at_shut, logic blocked,
                                        logic [ElapsedW-1:0] ms);
    dmc_in_t s;
    s.open_request      = req;
    s.other_door_closed = partner_shut;
    s.open_limit        = at_open;
    s.closed_limit      = at_shut;
    s.light_barrier     = blocked;
    s.elapsed_ms        = ms;
    return s;
  endfunction

  // Choose how much time passes between scans for the next burst
  task automatic pick_tick_range();
    case ($urandom_range(4, 0))
      0: begin ms_lo = 0;   ms_hi = 0;   end
      1: begin ms_lo = 255; ms_hi = 255; end
      2: begin ms_lo = 0;   ms_hi = 255; end
      default: begin ms_lo = 1; ms_hi = 40; end
    endcase
  endtask

  // Offer one scan after an optional gap and hold it until taken
  task automatic send_scan(dmc_in_t s);
    int unsigned gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap != 0) begin
      scan_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    scan_valid <= 1'b1;
    scan_data  <= s;
    @(posedge clk);
    while (scan_stall) @(posedge clk);
    scans_sent++;
  endtask

  task automatic put_register(dmc_cfg_idx_e idx, logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_timers(logic [CfgDataW-1:0] hold_v, logic [CfgDataW-1:0] blink_v,
                            logic [CfgDataW-1:0] timeout_v);
    put_register(CFG_HOLD_OPEN, hold_v);
    put_register(CFG_BLINK_HALF, blink_v);
    put_register(CFG_MOTOR_TIMEOUT, timeout_v);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_drained();
    scan_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // A plausible door cycle: request, travel, open limit, dwell, travel, close
  task automatic run_door_cycle();
    pick_tick_range();
    repeat ($urandom_range(2, 1))
      send_scan(door_scan(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, tick()));
    repeat ($urandom_range(6, 0))
      send_scan(door_scan(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, tick()));
    repeat ($urandom_range(3, 1))
      send_scan(door_scan(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, tick()));
    repeat ($urandom_range(30, 1))
      send_scan(door_scan(1'b0, chance(80), chance(50), 1'b0, chance(10), tick()));
    repeat ($urandom_range(8, 0))
      send_scan(door_scan(chance(5), chance(80), 1'b0, 1'b0, chance(8), tick()));
    repeat ($urandom_range(3, 1))
      send_scan(door_scan(1'b0, chance(80), 1'b0, 1'b1, 1'b0, tick()));
  endtask

  // A burst with its own odds for each input bit
  task automatic run_noise_burst();
    int unsigned levels [5] = '{0, 10, 50, 90, 100};
    int unsigned p [5];
    foreach (p[i]) p[i] = levels[$urandom_range(4, 0)];
    pick_tick_range();
    repeat ($urandom_range(30, 5))
      send_scan(door_scan(chance(p[0]), chance(p[1]), chance(p[2]), chance(p[3]),
                          chance(p[4]), tick()));
  endtask

  // Result side: runs of acceptance and stalls, plus one long hold-off
  always @(posedge clk) begin
    if (hold_off_req && !hold_off_taken) begin
      hold_off_taken <= 1'b1;
      result_stall   <= 1'b1;
      rx_count       <= HoldOffCycles;
    end else if (rx_count != 0) begin
      rx_count <= rx_count - 1;
    end else if (result_stall) begin
      result_stall <= 1'b0;
      rx_count     <= chance(10) ? $urandom_range(300, 100) : $urandom_range(30, 0);
    end else begin
      result_stall <= 1'b1;
      rx_count     <= pick_gap();
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned target;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset presets: start ajar, barrier reopens, reach the open limit
    send_scan(door_scan(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
    send_scan(door_scan(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 8'd255));
    send_scan(door_scan(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd255));
    send_scan(door_scan(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'd255));
    send_scan(door_scan(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'd255));
    wait_drained();

    // zero presets: each timer fires on the scan that starts it
    set_timers('0, '0, '0);
    send_scan(door_scan(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
    send_scan(door_scan(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0));
    send_scan(door_scan(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'd1));
    send_scan(door_scan(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0));
    send_scan(door_scan(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd255));
    send_scan(door_scan(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd255));
    send_scan(door_scan(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd255));
    wait_drained();

    // full-scale presets; timers left counting for the next, lower presets
    set_timers('1, '1, '1);
    send_scan(door_scan(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'd255));
    send_scan(door_scan(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
    send_scan(door_scan(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 8'd170));
    send_scan(door_scan(1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 8'd85));
    send_scan(door_scan(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'd255));

    for (int ph = 0; ph < RandomPhases; ph++) begin
      wait_drained();
      case (ph)
        0: set_timers(HoldOpenRst, BlinkHalfRst, MotorTimeoutRst);
        1: set_timers(16'd300, 16'd40, 16'd2000);
        2: set_timers('0, '0, '0);
        3: set_timers('0, '1, '1);
        default: set_timers(CfgDataW'($urandom_range(1500, 0)),
                            CfgDataW'($urandom_range(300, 0)),
                            CfgDataW'($urandom_range(4000, 100)));
      endcase
      // back-to-back scans in some phases; one of them meets the long stall
      tx_quiet = (ph == 1) || (ph == 4);
      if (ph == 1) hold_off_req <= 1'b1;
      target = scans_sent + ScansPerPhase;
      while (scans_sent < target) begin
        if (chance(70)) run_door_cycle();
        else run_noise_burst();
      end
    end

    wait_drained();
    if (error_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
